// ===== hw/rtl/lzeb_pkg.sv =====
// Shared types and constants for the LZ escape bitstream decompressor.
// No dependencies; every other file of the block except lzeb_ram imports this package.
package lzeb_pkg;

    localparam int unsigned CNT_W    = 17;
    localparam int unsigned LEN_W    = 21;
    localparam int unsigned OFF_W    = 17;
    localparam int unsigned HIST_N   = 16;
    localparam int unsigned HIST_W   = 4;

    localparam logic [LEN_W-1:0] END_MARK = 21'h100003;
    localparam logic [LEN_W-1:0] LEN_MAX  = 21'h1FFFFF;
    localparam logic [OFF_W-1:0] OFF_MAX  = 17'h1FFFF;
    localparam logic [CNT_W-1:0] CNT_MAX  = 17'h1FFFF;

    // Status codes.
    localparam logic [2:0] ST_RUN      = 3'd0;
    localparam logic [2:0] ST_OK       = 3'd1;
    localparam logic [2:0] ST_LEN_BAD  = 3'd2;
    localparam logic [2:0] ST_OFF_BAD  = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    // Configuration register indexes.
    localparam logic REG_SRC_LEN = 1'b0;
    localparam logic REG_THRESH  = 1'b1;

    typedef enum logic [4:0] {
        PH_HDR_WIDTH, PH_HDR_CHG, PH_HDR_ESC, PH_ITEM, PH_ESCBITS, PH_FLAG,
        PH_NEWESC, PH_LITREST, PH_RAW, PH_LEN2, PH_HIST, PH_GAM_D, PH_GAM_S,
        PH_OFF2, PH_OG_S, PH_OG_D, PH_OFF5, PH_FIN, PH_STORE, PH_START,
        PH_COPY_RD, PH_COPY
    } t_phase;

    typedef enum logic [1:0] {
        RES_GO, RES_STALL, RES_OUT
    } t_outcome;

    typedef enum logic {
        TS_IDLE, TS_RUN
    } t_top_state;

    // Bit reader status seen by the decoder.
    typedef struct packed {
        logic             bit_ok;
        logic             bit_val;
        logic             hold_valid;
        logic [7:0]       hold_byte;
        logic [CNT_W-1:0] consumed;
    } t_rd_stat;

    // Bit reader requests from the decoder.
    typedef struct packed {
        logic take_bit;
        logic take_raw;
    } t_rd_req;

    // Outcome of one decoder step.
    typedef struct packed {
        t_outcome         outcome;
        logic [7:0]       byte_val;
        logic [2:0]       status_next;
        logic [CNT_W-1:0] count_next;
    } t_step;

endpackage

// ===== hw/rtl/lzeb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lzeb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/lzeb_bitrd.sv =====
// Bit reader: one-byte input holder, MSB-first shift register, consumed count.
// Depends on lzeb_pkg.
module lzeb_bitrd
    import lzeb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_feed,
    input  logic [7:0] i_feed_byte,
    input  t_rd_req    i_req,
    output t_rd_stat   o_stat
);

    logic             r_hold_valid, n_hold_valid;
    logic [7:0]       r_hold_byte, n_hold_byte;
    logic [7:0]       r_buf, n_buf;
    logic [2:0]       r_left, n_left;
    logic [CNT_W-1:0] r_consumed, n_consumed;
    logic             take_byte;

    // A bit comes from the shift register, or from a fresh byte of the holder.
    assign take_byte = (i_req.take_bit && (r_left == 3'd0)) || i_req.take_raw;

    always_comb begin
        n_hold_valid = r_hold_valid;
        n_hold_byte  = r_hold_byte;
        n_buf        = r_buf;
        n_left       = r_left;
        n_consumed   = r_consumed;
        if (i_req.take_bit) begin
            if (r_left != 3'd0) begin
                n_buf  = {r_buf[6:0], 1'b0};
                n_left = r_left - 3'd1;
            end else begin
                n_buf  = r_hold_byte;
                n_left = 3'd7;
            end
        end
        if (take_byte) begin
            n_hold_valid = 1'b0;
            if (r_consumed != CNT_MAX) begin
                n_consumed = r_consumed + 1'b1;
            end
        end
        if (i_feed) begin
            n_hold_valid = 1'b1;
            n_hold_byte  = i_feed_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_buf        <= '0;
            r_left       <= '0;
            r_consumed   <= '0;
        end else begin
            r_hold_valid <= n_hold_valid;
            r_buf        <= n_buf;
            r_left       <= n_left;
            r_consumed   <= n_consumed;
        end
        r_hold_byte <= n_hold_byte;
    end

    // Status toward the decoder.
    always_comb begin
        o_stat.bit_ok     = (r_left != 3'd0) || r_hold_valid;
        o_stat.bit_val    = (r_left != 3'd0) ? r_buf[6] : r_hold_byte[7];
        o_stat.hold_valid = r_hold_valid;
        o_stat.hold_byte  = r_hold_byte;
        o_stat.consumed   = r_consumed;
    end

endmodule

// ===== hw/rtl/lzeb_dec.sv =====
// Decoder sequencer: header, literals, length/offset codes, history ring, copy.
// Depends on lzeb_pkg and lzeb_ram (window memory).
module lzeb_dec
    import lzeb_pkg::*;
#(
    parameter int unsigned WINDOW_DEPTH = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [CNT_W-1:0] i_src_len,
    input  logic [15:0]      i_thresh,
    input  t_rd_stat         i_rd,
    output t_rd_req          o_rd,
    output t_step            o_step,
    output logic [2:0]       o_status,
    output logic [CNT_W-1:0] o_count
);

    localparam int unsigned AW = $clog2(WINDOW_DEPTH);
    localparam logic [OFF_W-1:0] DEPTH_C = OFF_W'(WINDOW_DEPTH);

    t_phase           r_phase, n_phase;
    logic [1:0]       r_ew, n_ew;
    logic [2:0]       r_ecode, n_ecode;
    logic             r_echg, n_echg;
    logic [7:0]       r_lit, n_lit;
    logic [3:0]       r_cnt, n_cnt;
    logic             r_first, n_first;
    logic [LEN_W-1:0] r_len, n_len;
    logic [OFF_W-1:0] r_off, n_off;
    logic [OFF_W-1:0] r_prev, n_prev;
    logic [LEN_W-1:0] r_rem, n_rem;
    logic [OFF_W-1:0] r_dist, n_dist;
    logic [CNT_W-1:0] r_prod, n_prod;
    logic [2:0]       r_status, n_status;
    logic [HIST_W-1:0] r_ptr, n_ptr;
    logic [LEN_W-1:0] r_rlen [HIST_N];
    logic [OFF_W-1:0] r_roff [HIST_N];

    logic             needs_bit, b, stall, do_emit, ring_we, ram_we;
    logic [7:0]       emit_val, ram_rdata;
    logic [3:0]       cnt_inc;
    logic [3:0]       n_ext;
    logic [2:0]       esc_mask;
    logic [HIST_W-1:0] hidx;
    logic [LEN_W:0]   rem_sum;
    logic             off_inc;
    logic [OFF_W-1:0] off_sat;
    t_outcome         outcome;

    assign b        = i_rd.bit_val;
    assign cnt_inc  = r_cnt + 4'd1;
    assign n_ext    = {2'b00, r_ew};
    assign esc_mask = 3'((4'd1 << r_ew) - 4'd1);
    assign hidx     = {r_len[2:0], b};
    assign off_sat  = r_off[OFF_W-1] ? OFF_MAX : {r_off[OFF_W-2:0], b};
    assign off_inc  = r_off > {1'b0, i_thresh};
    assign rem_sum  = {1'b0, r_len} + (off_inc ? 22'd2 : 22'd1);

    // Phases that read one bit from the stream.
    always_comb begin
        unique case (r_phase)
            PH_ITEM, PH_RAW, PH_FIN, PH_STORE, PH_START, PH_COPY_RD,
            PH_COPY: needs_bit = 1'b0;
            default: needs_bit = 1'b1;
        endcase
    end

    assign stall = (needs_bit && !i_rd.bit_ok) || ((r_phase == PH_RAW) && !i_rd.hold_valid);
    assign o_rd.take_bit = i_step && needs_bit && i_rd.bit_ok;
    assign o_rd.take_raw = i_step && (r_phase == PH_RAW) && i_rd.hold_valid;

    // One decode step.
    always_comb begin
        n_phase  = r_phase;
        n_ew     = r_ew;
        n_ecode  = r_ecode;
        n_echg   = r_echg;
        n_lit    = r_lit;
        n_cnt    = r_cnt;
        n_first  = r_first;
        n_len    = r_len;
        n_off    = r_off;
        n_prev   = r_prev;
        n_rem    = r_rem;
        n_dist   = r_dist;
        n_prod   = r_prod;
        n_status = r_status;
        n_ptr    = r_ptr;
        do_emit  = 1'b0;
        emit_val = ram_rdata;
        ring_we  = 1'b0;
        ram_we   = 1'b0;
        outcome  = RES_GO;
        if (i_step && stall) begin
            outcome = RES_STALL;
        end else if (i_step) begin
            unique case (r_phase)
                PH_HDR_WIDTH: begin
                    n_ew  = {r_ew[0], b};
                    n_cnt = cnt_inc;
                    if (cnt_inc >= 4'd2) begin
                        n_cnt   = '0;
                        n_phase = ({r_ew[0], b} != 2'd0) ? PH_HDR_CHG : PH_ITEM;
                    end
                end
                PH_HDR_CHG: begin
                    n_echg  = b;
                    n_ecode = '0;
                    n_cnt   = '0;
                    n_phase = PH_HDR_ESC;
                end
                PH_HDR_ESC, PH_NEWESC: begin
                    n_ecode = {r_ecode[1:0], b};
                    n_cnt   = cnt_inc;
                    if (cnt_inc >= n_ext) begin
                        n_cnt   = '0;
                        n_phase = (r_phase == PH_NEWESC) ? PH_LITREST : PH_ITEM;
                    end
                end
                PH_ITEM: begin
                    n_lit   = '0;
                    n_cnt   = '0;
                    n_off   = '0;
                    n_phase = (r_ew != 2'd0) ? PH_ESCBITS : PH_FLAG;
                end
                PH_ESCBITS: begin
                    n_lit = {r_lit[6:0], b};
                    n_cnt = cnt_inc;
                    if (cnt_inc >= n_ext) begin
                        n_cnt   = '0;
                        n_phase = (({r_lit[1:0], b} & esc_mask) != r_ecode)
                                  ? PH_LITREST : PH_FLAG;
                    end
                end
                PH_FLAG: begin
                    n_cnt = '0;
                    if (b) begin
                        if (r_echg && (r_ew != 2'd0)) begin
                            n_ecode = '0;
                            n_phase = PH_NEWESC;
                        end else begin
                            n_phase = (r_ew != 2'd0) ? PH_LITREST : PH_RAW;
                        end
                    end else begin
                        n_len   = '0;
                        n_phase = PH_LEN2;
                    end
                end
                PH_LITREST: begin
                    n_lit = {r_lit[6:0], b};
                    n_cnt = cnt_inc;
                    if (cnt_inc >= (4'd8 - n_ext)) begin
                        n_phase  = PH_ITEM;
                        do_emit  = 1'b1;
                        emit_val = {r_lit[6:0], b};
                    end
                end
                PH_RAW: begin
                    n_phase  = PH_ITEM;
                    do_emit  = 1'b1;
                    emit_val = i_rd.hold_byte;
                end
                PH_LEN2: begin
                    n_len = {r_len[LEN_W-2:0], b};
                    n_cnt = cnt_inc;
                    if (cnt_inc >= 4'd2) begin
                        n_cnt = '0;
                        unique case ({r_len[0], b})
                            2'b01: begin
                                n_len   = '0;
                                n_phase = PH_HIST;
                            end
                            2'b00: begin
                                n_len   = LEN_W'(1);
                                n_phase = PH_GAM_D;
                            end
                            default: begin
                                n_len   = LEN_W'({r_len[0], b}) - LEN_W'(1);
                                n_phase = PH_FIN;
                            end
                        endcase
                    end
                end
                PH_HIST: begin
                    n_len = LEN_W'({r_len[2:0], b});
                    n_cnt = cnt_inc;
                    if (cnt_inc >= 4'd4) begin
                        n_cnt   = '0;
                        n_len   = r_rlen[hidx];
                        n_off   = r_roff[hidx];
                        n_phase = PH_FIN;
                    end
                end
                PH_GAM_D: begin
                    n_len   = r_len[LEN_W-1] ? LEN_MAX : {r_len[LEN_W-2:0], b};
                    n_phase = PH_GAM_S;
                end
                PH_GAM_S: begin
                    if (b) begin
                        if (r_len != LEN_MAX) begin
                            n_len = r_len + 1'b1;
                        end
                        n_phase = PH_FIN;
                    end else begin
                        n_phase = PH_GAM_D;
                    end
                end
                PH_OFF2: begin
                    if (r_cnt == 4'd0) begin
                        n_first = b;
                        n_cnt   = 4'd1;
                    end else begin
                        n_cnt = '0;
                        if (!r_first && !b) begin
                            n_off   = r_prev;
                            n_phase = PH_STORE;
                        end else begin
                            n_off   = OFF_W'(b);
                            n_phase = r_first ? PH_OFF5 : PH_OG_S;
                        end
                    end
                end
                PH_OG_S: begin
                    n_first = b;
                    n_phase = PH_OG_D;
                end
                PH_OG_D: begin
                    n_off = off_sat;
                    if (r_first) begin
                        n_cnt   = '0;
                        n_phase = PH_OFF5;
                    end else begin
                        n_phase = PH_OG_S;
                    end
                end
                PH_OFF5: begin
                    n_off = off_sat;
                    n_cnt = cnt_inc;
                    if (cnt_inc >= 4'd5) begin
                        n_cnt = '0;
                        if (off_sat != OFF_MAX) begin
                            n_off = off_sat + 1'b1;
                        end
                        n_phase = PH_STORE;
                    end
                end
                PH_FIN: begin
                    if (r_len == END_MARK) begin
                        n_status = (i_rd.consumed == i_src_len) ? ST_OK : ST_LEN_BAD;
                    end else if (r_off == '0) begin
                        n_cnt   = '0;
                        n_phase = PH_OFF2;
                    end else begin
                        n_phase = PH_START;
                    end
                end
                PH_STORE: begin
                    ring_we = 1'b1;
                    n_ptr   = r_ptr + 1'b1;
                    n_phase = PH_START;
                end
                PH_START: begin
                    n_prev = r_off;
                    if ((r_off > r_prod) || (r_off > DEPTH_C)) begin
                        n_status = ST_OFF_BAD;
                    end else begin
                        if (r_len == '0) begin
                            n_rem = LEN_W'(2);
                        end else if (rem_sum >= {1'b0, LEN_MAX}) begin
                            n_rem = LEN_MAX;
                        end else begin
                            n_rem = rem_sum[LEN_W-1:0];
                        end
                        n_dist  = r_off;
                        n_phase = PH_COPY_RD;
                    end
                end
                PH_COPY_RD: begin
                    n_phase = PH_COPY;
                end
                PH_COPY: begin
                    do_emit  = 1'b1;
                    emit_val = ram_rdata;
                    if (r_rem != '0) begin
                        n_rem = r_rem - 1'b1;
                    end
                    n_phase = ((r_rem == '0) || (r_rem == LEN_W'(1))) ? PH_ITEM : PH_COPY_RD;
                end
                default: begin
                    n_phase = PH_ITEM;
                end
            endcase
            // Write one byte to the output and the window, or flag overflow.
            if (do_emit) begin
                if (r_prod[CNT_W-1]) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    ram_we  = 1'b1;
                    n_prod  = r_prod + 1'b1;
                    outcome = RES_OUT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR_WIDTH;
            r_ew     <= '0;
            r_ecode  <= '0;
            r_echg   <= 1'b0;
            r_lit    <= '0;
            r_cnt    <= '0;
            r_first  <= 1'b0;
            r_len    <= '0;
            r_off    <= '0;
            r_prev   <= OFF_W'(1);
            r_rem    <= '0;
            r_dist   <= '0;
            r_prod   <= '0;
            r_status <= ST_RUN;
            r_ptr    <= '0;
            for (int i = 0; i < HIST_N; i++) begin
                r_rlen[i] <= '0;
                r_roff[i] <= '0;
            end
        end else begin
            r_phase  <= n_phase;
            r_ew     <= n_ew;
            r_ecode  <= n_ecode;
            r_echg   <= n_echg;
            r_lit    <= n_lit;
            r_cnt    <= n_cnt;
            r_first  <= n_first;
            r_len    <= n_len;
            r_off    <= n_off;
            r_prev   <= n_prev;
            r_rem    <= n_rem;
            r_dist   <= n_dist;
            r_prod   <= n_prod;
            r_status <= n_status;
            r_ptr    <= n_ptr;
            if (ring_we) begin
                r_rlen[r_ptr] <= r_len;
                r_roff[r_ptr] <= r_off;
            end
        end
    end

    // Window memory holds the most recent output bytes.
    lzeb_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_prod[AW-1:0]),
        .i_wdata (emit_val),
        .i_raddr (r_prod[AW-1:0] - r_dist[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_step.outcome     = outcome;
        o_step.byte_val    = emit_val;
        o_step.status_next = n_status;
        o_step.count_next  = n_prod;
    end

    assign o_status = r_status;
    assign o_count  = r_prod;

endmodule

// ===== hw/rtl/lz_escape_bitstream_decompressor_core.sv =====
// Top level of the LZ escape bitstream decompressor: handshake, registers, result.
// Depends on lzeb_pkg, lzeb_bitrd, lzeb_dec (which uses lzeb_ram).
//
//  Port group    Direction  Handshake           Payload
//  input item    in         i_valid / o_ready   i_op, i_src_byte
//  result        out        o_valid / i_ready   o_out_byte .. o_out_count
//  config        in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// A feed (op 0) loads its result in its accept cycle. A pull (op 1) is accepted
// and then runs decoder steps: one stream bit per step, one setup step per item,
// a few bookkeeping steps per match, and a read step and an output step per
// copied byte (registered window read). The result shows on o_valid next cycle.
// Reset is synchronous; the history ring is cleared by reset at once.
// A new item is taken only when the result register is empty or being taken.
module lz_escape_bitstream_decompressor_core
    import lzeb_pkg::*;
#(
    parameter int unsigned WINDOW_DEPTH = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_op,
    input  logic [7:0]       i_src_byte,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_out_valid,
    output logic             o_need_input,
    output logic [2:0]       o_status,
    output logic [CNT_W-1:0] o_out_count,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CNT_W-1:0] i_cfg_data
);

    t_top_state       r_state, n_state;
    logic [CNT_W-1:0] r_src_len;
    logic [15:0]      r_thresh;
    logic             r_res_valid, r_res_ov, r_res_need;
    logic [7:0]       r_res_byte;
    logic [2:0]       r_res_status;
    logic [CNT_W-1:0] r_res_count;

    logic             accept, slot_free, step, feed, res_load;
    logic             res_ov, res_need;
    logic [7:0]       res_byte;
    logic [2:0]       res_status, dec_status;
    logic [CNT_W-1:0] res_count, dec_count;
    t_rd_stat         rd_stat;
    t_rd_req          rd_req;
    t_step            step_res;

    assign slot_free = !r_res_valid || i_ready;
    assign accept    = i_valid && o_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            TS_IDLE: begin
                if (accept && i_op && (dec_status == ST_RUN)) begin
                    n_state = TS_RUN;
                end
            end
            TS_RUN: begin
                if ((step_res.outcome != RES_GO) || (step_res.status_next != ST_RUN)) begin
                    n_state = TS_IDLE;
                end
            end
            default: n_state = TS_IDLE;
        endcase
    end

    // Outputs of the control sequencer.
    always_comb begin
        o_ready    = 1'b0;
        step       = 1'b0;
        feed       = 1'b0;
        res_load   = 1'b0;
        res_ov     = 1'b0;
        res_need   = 1'b0;
        res_byte   = '0;
        res_status = dec_status;
        res_count  = dec_count;
        unique case (r_state)
            TS_IDLE: begin
                o_ready = slot_free;
                if (accept) begin
                    if (!i_op) begin
                        feed     = (dec_status == ST_RUN) && !rd_stat.hold_valid;
                        res_load = 1'b1;
                    end else if (dec_status != ST_RUN) begin
                        res_load = 1'b1;
                    end
                end
            end
            TS_RUN: begin
                step       = 1'b1;
                res_status = step_res.status_next;
                res_count  = step_res.count_next;
                if ((step_res.outcome != RES_GO) || (step_res.status_next != ST_RUN)) begin
                    res_load = 1'b1;
                    res_ov   = (step_res.outcome == RES_OUT);
                    res_need = (step_res.outcome == RES_STALL);
                    res_byte = res_ov ? step_res.byte_val : 8'd0;
                end
            end
            default: ;
        endcase
    end

    // Control state, configuration and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= TS_IDLE;
            r_src_len   <= '0;
            r_thresh    <= 16'd255;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_SRC_LEN: r_src_len <= i_cfg_data;
                    REG_THRESH:  r_thresh  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (res_load) begin
                r_res_valid <= 1'b1;
            end else if (i_ready) begin
                r_res_valid <= 1'b0;
            end
        end
        if (res_load) begin
            r_res_byte   <= res_byte;
            r_res_ov     <= res_ov;
            r_res_need   <= res_need;
            r_res_status <= res_status;
            r_res_count  <= res_count;
        end
    end

    lzeb_bitrd u_bitrd (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_feed      (feed),
        .i_feed_byte (i_src_byte),
        .i_req       (rd_req),
        .o_stat      (rd_stat)
    );

    lzeb_dec #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_src_len (r_src_len),
        .i_thresh  (r_thresh),
        .i_rd      (rd_stat),
        .o_rd      (rd_req),
        .o_step    (step_res),
        .o_status  (dec_status),
        .o_count   (dec_count)
    );

    assign o_valid      = r_res_valid;
    assign o_out_byte   = r_res_byte;
    assign o_out_valid  = r_res_ov;
    assign o_need_input = r_res_need;
    assign o_status     = r_res_status;
    assign o_out_count  = r_res_count;

    // No new transfer is taken while a pull is being decoded.
    a_no_accept_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == TS_RUN) |-> !o_ready)
        else $error("input accepted during decode");

    // A result never carries both a byte and a stall.
    a_byte_or_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_out_valid && o_need_input))
        else $error("result has byte and stall");

    // A produced byte comes only while the decoder is running.
    a_byte_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_valid) |-> (o_status == ST_RUN))
        else $error("byte produced with nonzero status");

    // Decoding a pull ends once the decoder stops.
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == TS_RUN) && (step_res.status_next != ST_RUN)) |=> (r_state == TS_IDLE))
        else $error("decoder kept running after stop");

endmodule

// ===== tb/sv/tb_lz_escape_bitstream_decompressor_core.sv =====
// Self-checking testbench for lz_escape_bitstream_decompressor_core.
// It encodes one random compressed stream, feeds it and pulls output bytes, and checks every
// result against a cycle-free decoder model. Depends on lzeb_pkg and the core only.
module tb_lz_escape_bitstream_decompressor_core;
    import lzeb_pkg::*;

    typedef struct packed {
        logic             op;
        logic [7:0]       src;
    } t_item;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             out_valid;
        logic             need_input;
        logic [2:0]       status;
        logic [CNT_W-1:0] out_count;
    } t_result;

    localparam logic OP_FEED = 1'b0;
    localparam logic OP_PULL = 1'b1;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_op = 1'b0;
    logic [7:0]       in_src = 8'h00;
    logic             out_ready = 1'b0;
    logic             cfg_we = 1'b0;
    logic             cfg_idx = 1'b0;
    logic [CNT_W-1:0] cfg_data = '0;
    logic             o_ready;
    logic             o_valid;
    logic [7:0]       o_out_byte;
    logic             o_out_valid;
    logic             o_need_input;
    logic [2:0]       o_status;
    logic [CNT_W-1:0] o_out_count;

    t_item   item_q[$];
    t_result decoded_q[$];
    int      errors = 0;
    bit      quiet = 1'b0;
    int      in_gap = 0;
    int      out_gap = 0;

    lz_escape_bitstream_decompressor_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (in_valid),
        .o_ready      (o_ready),
        .i_op         (in_op),
        .i_src_byte   (in_src),
        .o_valid      (o_valid),
        .i_ready      (out_ready),
        .o_out_byte   (o_out_byte),
        .o_out_valid  (o_out_valid),
        .o_need_input (o_need_input),
        .o_status     (o_status),
        .o_out_count  (o_out_count),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data)
    );

    // Clock.
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Decoder model state.
    int unsigned m_src_len = 0;
    int unsigned m_thresh = 255;
    logic [7:0]  m_bits = 0;
    int unsigned m_bits_left = 0;
    int unsigned m_consumed = 0;
    int unsigned m_produced = 0;
    logic [7:0]  m_window [0:65535];
    int unsigned m_hist_len [16];
    int unsigned m_hist_off [16];
    int unsigned m_hist_ptr = 0;
    logic [1:0]  m_esc_w = 0;
    logic [2:0]  m_esc = 0;
    logic        m_esc_chg = 0;
    int unsigned m_prev_off = 1;
    t_phase      m_phase = PH_HDR_WIDTH;
    int unsigned m_copy_left = 0;
    int unsigned m_copy_dist = 0;
    logic        m_hold_valid = 0;
    logic [7:0]  m_hold = 0;
    logic [2:0]  m_status = ST_RUN;
    logic [7:0]  m_lit = 0;
    int unsigned m_cnt = 0;
    logic        m_first = 0;
    int unsigned m_len = 0;
    int unsigned m_off = 0;

    function automatic void take_held();
        m_hold_valid = 1'b0;
        if (m_consumed < CNT_MAX) m_consumed++;
    endfunction

    function automatic logic next_bit(output logic b);
        if (m_bits_left != 0) begin
            m_bits = m_bits << 1;
            m_bits_left--;
        end else begin
            if (!m_hold_valid) return 1'b0;
            m_bits = m_hold;
            take_held();
            m_bits_left = 7;
        end
        b = m_bits[7];
        return 1'b1;
    endfunction

    function automatic int unsigned sat_shl(int unsigned v, logic b, int unsigned lim);
        longint unsigned r;
        r = (longint'(v) << 1) | b;
        return (r > lim) ? lim : int'(r);
    endfunction

    function automatic t_outcome put_out(logic [7:0] v, output logic [7:0] ob);
        if (m_produced >= 65536) begin
            m_status = ST_OVERFLOW;
            return RES_GO;
        end
        m_window[m_produced[15:0]] = v;
        m_produced++;
        ob = v;
        return RES_OUT;
    endfunction

    function automatic t_outcome begin_copy();
        m_prev_off = m_off;
        if (m_off > m_thresh && m_len < LEN_MAX) m_len++;
        if (m_off > m_produced || m_off > 65536) begin
            m_status = ST_OFF_BAD;
            return RES_GO;
        end
        m_copy_left = (m_len == 0) ? 2 : ((m_len >= LEN_MAX) ? LEN_MAX : m_len + 1);
        m_copy_dist = m_off;
        m_phase = PH_COPY;
        return RES_GO;
    endfunction

    function automatic t_outcome remember_and_copy();
        m_hist_len[m_hist_ptr] = m_len;
        m_hist_off[m_hist_ptr] = m_off;
        m_hist_ptr = (m_hist_ptr + 1) & 15;
        return begin_copy();
    endfunction

    function automatic t_outcome length_done();
        if (m_len == END_MARK) begin
            m_status = (m_consumed == m_src_len) ? ST_OK : ST_LEN_BAD;
            return RES_GO;
        end
        if (m_off == 0) begin
            m_cnt = 0;
            m_phase = PH_OFF2;
            return RES_GO;
        end
        return begin_copy();
    endfunction

    // One decoder step.
    function automatic t_outcome decode_step(output logic [7:0] ob);
        logic        b;
        int unsigned n;
        int unsigned idx;
        logic [7:0]  v;
        t_outcome    r;
        n = m_esc_w;
        ob = 8'h00;
        case (m_phase)
            PH_HDR_WIDTH: begin
                if (!next_bit(b)) return RES_STALL;
                m_esc_w = {m_esc_w[0], b};
                if (++m_cnt >= 2) begin
                    m_cnt = 0;
                    m_phase = (m_esc_w != 0) ? PH_HDR_CHG : PH_ITEM;
                end
            end
            PH_HDR_CHG: begin
                if (!next_bit(b)) return RES_STALL;
                m_esc_chg = b;
                m_esc = 0;
                m_cnt = 0;
                m_phase = PH_HDR_ESC;
            end
            PH_HDR_ESC: begin
                if (!next_bit(b)) return RES_STALL;
                m_esc = {m_esc[1:0], b};
                if (++m_cnt >= n) begin
                    m_cnt = 0;
                    m_phase = PH_ITEM;
                end
            end
            PH_ITEM: begin
                m_lit = 0;
                m_cnt = 0;
                m_off = 0;
                m_phase = (n != 0) ? PH_ESCBITS : PH_FLAG;
            end
            PH_ESCBITS: begin
                if (!next_bit(b)) return RES_STALL;
                m_lit = {m_lit[6:0], b};
                if (++m_cnt >= n) begin
                    m_cnt = 0;
                    m_phase = ((m_lit & ((8'd1 << n) - 1)) != m_esc) ? PH_LITREST : PH_FLAG;
                end
            end
            PH_FLAG: begin
                if (!next_bit(b)) return RES_STALL;
                m_cnt = 0;
                if (b) begin
                    if (m_esc_chg && n != 0) begin
                        m_esc = 0;
                        m_phase = PH_NEWESC;
                    end else begin
                        m_phase = (n != 0) ? PH_LITREST : PH_RAW;
                    end
                end else begin
                    m_len = 0;
                    m_phase = PH_LEN2;
                end
            end
            PH_NEWESC: begin
                if (!next_bit(b)) return RES_STALL;
                m_esc = {m_esc[1:0], b};
                if (++m_cnt >= n) begin
                    m_cnt = 0;
                    m_phase = PH_LITREST;
                end
            end
            PH_LITREST: begin
                if (!next_bit(b)) return RES_STALL;
                m_lit = {m_lit[6:0], b};
                if (++m_cnt >= 8 - n) begin
                    m_phase = PH_ITEM;
                    return put_out(m_lit, ob);
                end
            end
            PH_RAW: begin
                if (!m_hold_valid) return RES_STALL;
                take_held();
                m_phase = PH_ITEM;
                return put_out(m_hold, ob);
            end
            PH_LEN2: begin
                if (!next_bit(b)) return RES_STALL;
                m_len = (m_len << 1) | b;
                if (++m_cnt >= 2) begin
                    m_cnt = 0;
                    if (m_len == 1) begin
                        m_len = 0;
                        m_phase = PH_HIST;
                    end else if (m_len == 0) begin
                        m_len = 1;
                        m_phase = PH_GAM_D;
                    end else begin
                        m_len--;
                        return length_done();
                    end
                end
            end
            PH_HIST: begin
                if (!next_bit(b)) return RES_STALL;
                m_len = ((m_len << 1) | b) & 15;
                if (++m_cnt >= 4) begin
                    idx = m_len;
                    m_cnt = 0;
                    m_len = m_hist_len[idx];
                    m_off = m_hist_off[idx];
                    return length_done();
                end
            end
            PH_GAM_D: begin
                if (!next_bit(b)) return RES_STALL;
                m_len = sat_shl(m_len, b, LEN_MAX);
                m_phase = PH_GAM_S;
            end
            PH_GAM_S: begin
                if (!next_bit(b)) return RES_STALL;
                if (b) begin
                    if (m_len < LEN_MAX) m_len++;
                    return length_done();
                end
                m_phase = PH_GAM_D;
            end
            PH_OFF2: begin
                if (!next_bit(b)) return RES_STALL;
                if (m_cnt == 0) begin
                    m_first = b;
                    m_cnt = 1;
                    return RES_GO;
                end
                m_cnt = 0;
                if (!m_first && !b) begin
                    m_off = m_prev_off;
                    return remember_and_copy();
                end
                m_off = b;
                m_phase = m_first ? PH_OFF5 : PH_OG_S;
            end
            PH_OG_S: begin
                if (!next_bit(b)) return RES_STALL;
                m_first = b;
                m_phase = PH_OG_D;
            end
            PH_OG_D: begin
                if (!next_bit(b)) return RES_STALL;
                m_off = sat_shl(m_off, b, OFF_MAX);
                if (m_first) begin
                    m_cnt = 0;
                    m_phase = PH_OFF5;
                end else begin
                    m_phase = PH_OG_S;
                end
            end
            PH_OFF5: begin
                if (!next_bit(b)) return RES_STALL;
                m_off = sat_shl(m_off, b, OFF_MAX);
                if (++m_cnt >= 5) begin
                    m_cnt = 0;
                    if (m_off < OFF_MAX) m_off++;
                    return remember_and_copy();
                end
            end
            PH_COPY: begin
                v = m_window[16'(m_produced - m_copy_dist)];
                r = put_out(v, ob);
                if (m_copy_left != 0) m_copy_left--;
                if (m_copy_left == 0) m_phase = PH_ITEM;
                return r;
            end
            default: begin
                m_phase = PH_ITEM;
            end
        endcase
        return RES_GO;
    endfunction

    // Result of one item: a feed fills an empty holder, a pull runs until a byte, a stall or a stop.
    function automatic t_result decode_item(t_item it);
        t_result  res;
        logic [7:0] ob;
        logic     got;
        logic     need;
        t_outcome r;
        got = 0;
        need = 0;
        ob = 0;
        if (it.op == OP_FEED) begin
            if (m_status == ST_RUN && !m_hold_valid) begin
                m_hold = it.src;
                m_hold_valid = 1'b1;
            end
            need = (m_status == ST_RUN) && !m_hold_valid;
        end else begin
            while (m_status == ST_RUN) begin
                r = decode_step(ob);
                if (r == RES_OUT) begin
                    got = 1;
                    break;
                end
                if (r == RES_STALL) begin
                    need = 1;
                    break;
                end
            end
        end
        res.out_byte = got ? ob : 8'h00;
        res.out_valid = got;
        res.need_input = need && (m_status == ST_RUN);
        res.status = m_status;
        res.out_count = m_produced[CNT_W-1:0];
        return res;
    endfunction

    // Stream encoder. Raw bytes wait until the partly written bit byte is complete.
    logic [7:0]  stream_q[$];
    logic [7:0]  raw_wait_q[$];
    logic [7:0]  w_cur = 0;
    int unsigned w_n = 0;
    int unsigned g_made = 0;
    int unsigned g_prev = 1;
    int unsigned g_hist_len [16];
    int unsigned g_hist_off [16];
    int unsigned g_hist_ptr = 0;
    int unsigned g_w = 0;
    logic [2:0]  g_esc = 0;
    logic        g_chg = 0;

    function automatic void put_bit(logic b);
        w_cur = {w_cur[6:0], b};
        if (++w_n == 8) begin
            stream_q.push_back(w_cur);
            while (raw_wait_q.size() != 0) stream_q.push_back(raw_wait_q.pop_front());
            w_n = 0;
        end
    endfunction

    function automatic void put_bits(int unsigned v, int unsigned n);
        for (int i = int'(n) - 1; i >= 0; i--) put_bit(v[i]);
    endfunction

    function automatic int top_bit(int unsigned v);
        int k;
        k = 0;
        for (int i = 0; i < 32; i++) if (v[i]) k = i;
        return k;
    endfunction

    function automatic void put_gamma(int unsigned g);
        for (int i = top_bit(g) - 1; i >= 0; i--) begin
            put_bit(g[i]);
            put_bit(i == 0);
        end
    endfunction

    // Offset code: repeat of the last one, a short six-bit form, or the long gamma form.
    function automatic int unsigned put_offset();
        int unsigned o;
        int unsigned v;
        int unsigned hi;
        if ($urandom_range(0, 3) == 0) begin
            put_bits(0, 2);
            return g_prev;
        end
        case ($urandom_range(0, 3))
            0: o = 1;
            1: o = g_made;
            2: o = $urandom_range(1, (g_made < 64) ? g_made : 64);
            default: o = $urandom_range(1, g_made);
        endcase
        v = o - 1;
        if (v < 64) begin
            put_bit(1'b1);
            put_bits(v, 6);
        end else begin
            put_bits(2'b01, 2);
            hi = v >> 5;
            for (int i = top_bit(hi) - 1; i >= 0; i--) begin
                put_bit(i == 0);
                put_bit(hi[i]);
            end
            put_bits(v & 31, 5);
        end
        return o;
    endfunction

    function automatic void put_literal();
        logic [7:0] v;
        logic [2:0] nesc;
        v = $urandom_range(0, 255);
        if (g_w == 0) begin
            put_bit(1'b0 ^ 1'b1);
            if (w_n == 0) stream_q.push_back(v);
            else raw_wait_q.push_back(v);
        end else begin
            if ($urandom_range(0, 2) == 0) v = (v >> g_w) | (8'(g_esc) << (8 - g_w));
            if ((v >> (8 - g_w)) != g_esc) begin
                put_bits(v, 8);
            end else begin
                put_bits(g_esc, g_w);
                put_bit(1'b1);
                if (g_chg) begin
                    nesc = $urandom_range(0, (1 << g_w) - 1);
                    put_bits(nesc, g_w);
                    g_esc = nesc;
                end
                put_bits(v, 8 - g_w);
            end
        end
        g_made++;
    endfunction

    function automatic void put_match(int kind);
        int unsigned len;
        int unsigned off;
        int unsigned idx;
        bit          store;
        if (g_w != 0) put_bits(g_esc, g_w);
        put_bit(1'b0);
        store = 1;
        if (kind == 0) begin
            idx = $urandom_range(0, 15);
            put_bits(2'b01, 2);
            put_bits(idx, 4);
            len = g_hist_len[idx];
            off = g_hist_off[idx];
            if (off != 0) store = 0;
        end else if (kind == 1) begin
            len = $urandom_range(1, 2);
            put_bits(len + 1, 2);
            off = 0;
        end else begin
            len = ($urandom_range(0, 29) == 0) ? $urandom_range(13, 300) : $urandom_range(3, 12);
            put_bits(0, 2);
            put_gamma(len - 1);
            off = 0;
        end
        if (off == 0) off = put_offset();
        if (store) begin
            g_hist_len[g_hist_ptr] = len;
            g_hist_off[g_hist_ptr] = off;
            g_hist_ptr = (g_hist_ptr + 1) & 15;
        end
        g_prev = off;
        // Lower bound of output: a long offset may add one more byte.
        g_made += (len == 0) ? 2 : len + 1;
    endfunction

    // Header, then literals and matches, then the end marker.
    function automatic void build_stream(int tokens);
        g_w = $urandom_range(0, 3);
        put_bits(g_w, 2);
        if (g_w != 0) begin
            g_chg = $urandom_range(0, 1);
            g_esc = $urandom_range(0, (1 << g_w) - 1);
            put_bit(g_chg);
            put_bits(g_esc, g_w);
        end
        put_literal();
        put_match(0);
        for (int t = 0; t < tokens; t++) begin
            if ($urandom_range(0, 1) == 0) put_literal();
            else put_match($urandom_range(0, 9) < 2 ? 0 : ($urandom_range(0, 2) == 0 ? 1 : 2));
        end
        if (g_w != 0) put_bits(g_esc, g_w);
        put_bit(1'b0);
        put_bits(0, 2);
        put_gamma(END_MARK - 1);
        if (w_n != 0) put_bits($urandom_range(0, 255), 8 - w_n);
    endfunction

    function automatic void add_item(logic op, logic [7:0] src);
        t_item it;
        it.op = op;
        it.src = src;
        item_q.push_back(it);
        decoded_q.push_back(decode_item(it));
    endfunction

    // Mostly feed the stream when the holder is empty, else pull; a little noise.
    function automatic void add_traffic(int count, ref int pos);
        for (int k = 0; k < count && m_status == ST_RUN; k++) begin
            if (!m_hold_valid && pos < stream_q.size() && $urandom_range(0, 9) != 0) begin
                add_item(OP_FEED, stream_q[pos]);
                pos++;
            end else if (m_hold_valid && $urandom_range(0, 15) == 0) begin
                add_item(OP_FEED, $urandom_range(0, 255));
            end else begin
                add_item(OP_PULL, $urandom_range(0, 255));
            end
        end
    endfunction

    task automatic wait_idle();
        wait (item_q.size() == 0 && !in_valid && decoded_q.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [CNT_W-1:0] src_len, logic [15:0] thresh);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= REG_SRC_LEN;
        cfg_data <= src_len;
        @(posedge i_clk);
        cfg_idx <= REG_THRESH;
        cfg_data <= CNT_W'(thresh);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        m_src_len = src_len;
        m_thresh = thresh;
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Input driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_gap <= 0;
        end else if (!in_valid || o_ready) begin
            if (in_gap != 0) begin
                in_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end else if (!quiet && $urandom_range(0, 19) == 0) begin
                in_valid <= 1'b0;
                in_gap <= $urandom_range(0, 10);
            end else if (item_q.size() != 0) begin
                in_valid <= 1'b1;
                in_op <= item_q[0].op;
                in_src <= item_q[0].src;
                void'(item_q.pop_front());
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result monitor and back-pressure.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            out_gap <= 0;
        end else begin
            if (out_gap != 0) begin
                out_ready <= 1'b0;
                out_gap <= out_gap - 1;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
                out_ready <= 1'b0;
                out_gap <= $urandom_range(0, 10);
            end else begin
                out_ready <= 1'b1;
            end
            if (o_valid && out_ready) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch("unexpected transfer", o_out_count, 0);
                end else begin
                    want = decoded_q.pop_front();
                    if (o_out_byte !== want.out_byte)
                        report_mismatch("out_byte", o_out_byte, want.out_byte);
                    if (o_out_valid !== want.out_valid)
                        report_mismatch("out_valid", o_out_valid, want.out_valid);
                    if (o_need_input !== want.need_input)
                        report_mismatch("need_input", o_need_input, want.need_input);
                    if (o_status !== want.status)
                        report_mismatch("status", o_status, want.status);
                    if (o_out_count !== want.out_count)
                        report_mismatch("out_count", o_out_count, want.out_count);
                end
            end
        end
    end

    // Main sequence: reset, then phases of traffic with register writes in between.
    initial begin
        int pos;
        logic [CNT_W-1:0] src_lens [4];
        logic [15:0] threshs [4];
        pos = 0;
        src_lens = '{17'd0, 17'd65536, 17'd0, 17'd0};
        threshs = '{16'd0, 16'd65535, 16'd1, 16'd0};
        src_lens[2] = $urandom_range(0, 65536);
        src_lens[3] = $urandom_range(0, 65536);
        threshs[3] = $urandom_range(0, 65535);
        build_stream(230);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int p = 0; p < 4; p++) begin
            write_regs(src_lens[p], threshs[p]);
            if (p == 0) begin
                // A pull with nothing fed, then one feed and two feeds that find the holder full.
                add_item(OP_PULL, 8'h00);
                add_item(OP_FEED, stream_q[pos]);
                pos++;
                add_item(OP_FEED, 8'h00);
                add_item(OP_FEED, 8'hFF);
            end
            add_traffic(300, pos);
            wait_idle();
        end
        // Last phase: source length either right or off by one, no idling, run to the end.
        write_regs(stream_q.size() + $urandom_range(0, 1), $urandom_range(0, 65535));
        quiet = 1'b1;
        while (m_status == ST_RUN) add_traffic(50, pos);
        for (int k = 0; k < 6; k++) add_item(k[0] ? OP_PULL : OP_FEED, $urandom_range(0, 255));
        wait_idle();
        repeat (30) @(posedge i_clk);
        if (errors == 0) begin
            $display("lz_escape_bitstream_decompressor_core verification clean");
        end else begin
            $display("lz_escape_bitstream_decompressor_core verification failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #24000000;
        $display("lz_escape_bitstream_decompressor_core verification failed");
        $finish;
    end

endmodule
